// ===== sv/gspc_pkg.sv =====
// Shared types, status codes and constants for the gas sensor ppm converter.
// No dependencies; imported by every module of the block.
package gspc_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_CAL_VALID  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIVIDER    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SUPPLY     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LOAD       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CLEAN_AIR  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SCALE      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_EXPONENT   = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_CAL   = 2'd2;

  // 10000 ppm in Q14.8
  localparam logic [21:0] PPM_LIMIT = 22'd2560000;

  // Per-sample sideband carried along the pipeline
  typedef struct packed {
    logic signed [16:0] adc;
    logic [1:0]         status;
    logic [31:0]        res;
    logic               res_ok;
    logic               done;   // result settled early, later stages pass it on
    logic               sat;    // ratio saturates
  } item_t;

  localparam int ItemW = $bits(item_t);

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bt;
    x  = v;
    r  = '0;
    bt = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q2.30, built by repeated truncating square roots
  function automatic logic [31:0] exp_const(input int k);
    logic [63:0] c;
    c = isqrt64(64'h2000_0000_0000_0000);
    for (int j = 1; j < 16; j++) begin
      if (j < k) begin
        c = isqrt64(c << 30);
      end
    end
    return c[31:0];
  endfunction

endpackage

// ===== sv/gspc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on gspc_pkg for the sideband width only.
module gspc_div import gspc_pkg::*; #(
  parameter int QW = 32,
  parameter int DW = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DW-1:0]    rem_i,   // upper dividend part, below den_i
  input  logic [QW-1:0]    num_i,   // dividend bits still to bring down
  input  logic [DW-1:0]    den_i,
  input  logic [ItemW-1:0] side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quo_o,
  output logic [ItemW-1:0] side_o
);

  logic             vld  [QW+1];
  logic [DW-1:0]    rem  [QW+1];
  logic [QW-1:0]    num  [QW+1];
  logic [DW-1:0]    den  [QW+1];
  logic [ItemW-1:0] side [QW+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = rem_i;
  assign num[0]  = num_i;
  assign den[0]  = den_i;
  assign side[0] = side_i;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0]   t;
    logic          ge;
    logic [DW-1:0] rem_d;
    logic [QW-1:0] num_d;

    always_comb begin
      t     = {rem[i], num[i][QW-1]};
      ge    = (t >= {1'b0, den[i]});
      rem_d = ge ? DW'(t - {1'b0, den[i]}) : t[DW-1:0];
      // shift the quotient bit in as the dividend bit leaves
      num_d = {num[i][QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[i+1] <= 1'b0;
      end else if (en_i) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[i+1]  <= rem_d;
        num[i+1]  <= num_d;
        den[i+1]  <= den[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign valid_o = vld[QW];
  assign quo_o   = num[QW];
  assign side_o  = side[QW];

endmodule

// ===== sv/gas_sensor_ppm_convert.sv =====
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output register is full and stalled.
// Depth is set by the two bit-serial dividers (32 and 24 stages) and the
// 16-stage log2 squaring and exp2 product chains.
// Reset clears every stage valid bit and loads the register reset values.
module gas_sensor_ppm_convert import gspc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [16:0]  adc_mv_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic signed [16:0]  adc_echo_mv_o,
  output logic [31:0]         resistance_ohm_o,
  output logic                resistance_ok_o,
  output logic [21:0]         co_ppm_o,
  output logic                co_ppm_ok_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // ---------------- configuration ----------------
  logic               cal_valid_q;
  logic [23:0]        divider_q;
  logic [15:0]        supply_q;
  logic [19:0]        load_q;
  logic [23:0]        clean_air_q;
  logic [31:0]        scale_q;
  logic signed [20:0] exponent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_valid_q <= 1'b0;
      divider_q   <= 24'd65536;
      supply_q    <= 16'd5000;
      load_q      <= 20'd10000;
      clean_air_q <= '0;
      scale_q     <= '0;
      exponent_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CAL_VALID: cal_valid_q <= cfg_data_i[0];
        CFG_DIVIDER:   divider_q   <= cfg_data_i[23:0];
        CFG_SUPPLY:    supply_q    <= cfg_data_i[15:0];
        CFG_LOAD:      load_q      <= cfg_data_i[19:0];
        CFG_CLEAN_AIR: clean_air_q <= cfg_data_i[23:0];
        CFG_SCALE:     scale_q     <= cfg_data_i;
        CFG_EXPONENT:  exponent_q  <= cfg_data_i[20:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------- stage 1: screen sample, Vo ----------------
  logic        s1_vld_q;
  item_t       s1_it_q, s1_it_d;
  logic [39:0] s1_vo_q;

  always_comb begin
    s1_it_d        = '0;
    s1_it_d.adc    = adc_mv_i;
    s1_it_d.status = ST_RANGE;
    if (adc_mv_i[16] || adc_mv_i == '0) begin
      s1_it_d.done = 1'b1;
    end else if (!cal_valid_q || divider_q == '0 || supply_q == '0 || load_q == '0 ||
                 clean_air_q == '0 || scale_q == '0 || !exponent_q[20]) begin
      s1_it_d.done   = 1'b1;
      s1_it_d.status = ST_CAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_it_q <= s1_it_d;
      s1_vo_q <= 40'(adc_mv_i[15:0]) * 40'(divider_q);
    end
  end

  // ---------------- stage 2: compare with supply ----------------
  logic        s2_vld_q;
  item_t       s2_it_q, s2_it_d;
  logic [31:0] s2_vo_q, s2_diff_q;
  logic [31:0] vs;

  always_comb begin
    vs      = {supply_q, 16'h0000};
    s2_it_d = s1_it_q;
    if (!s1_it_q.done && s1_vo_q >= 40'(vs)) begin
      s2_it_d.done = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_it_q   <= s2_it_d;
      s2_vo_q   <= s1_vo_q[31:0];
      s2_diff_q <= vs - s1_vo_q[31:0];
    end
  end

  // ---------------- stage 3: numerator ----------------
  logic        s3_vld_q;
  item_t       s3_it_q;
  logic [31:0] s3_vo_q;
  logic [51:0] s3_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_it_q  <= s2_it_q;
      s3_vo_q  <= s2_vo_q;
      s3_num_q <= 52'(load_q) * 52'(s2_diff_q);
    end
  end

  // ---------------- stage 4: resistance saturation ----------------
  logic        s4_vld_q;
  item_t       s4_it_q, s4_it_d;
  logic [31:0] s4_vo_q, s4_rem_q, s4_lo_q;

  always_comb begin
    s4_it_d = s3_it_q;
    // quotient needs more than 32 bits when the upper part reaches the divisor
    if (!s3_it_q.done && 32'(s3_num_q[51:32]) >= s3_vo_q) begin
      s4_it_d.done = 1'b1;
      s4_it_d.res  = 32'hFFFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_it_q  <= s4_it_d;
      s4_vo_q  <= s3_vo_q;
      s4_rem_q <= 32'(s3_num_q[51:32]);
      s4_lo_q  <= s3_num_q[31:0];
    end
  end

  logic             d1_vld;
  logic [31:0]      d1_quo;
  logic [ItemW-1:0] d1_side;

  gspc_div #(.QW(32), .DW(32)) u_div_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_vld_q),
    .rem_i   (s4_rem_q),
    .num_i   (s4_lo_q),
    .den_i   (s4_vo_q),
    .side_i  (s4_it_q),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .side_o  (d1_side)
  );

  // ---------------- stage 5: resistance, ratio setup ----------------
  logic        s5_vld_q;
  item_t       s5_it_q, s5_it_d;
  logic [23:0] s5_rem_q, s5_lo_q;

  always_comb begin
    s5_it_d = item_t'(d1_side);
    if (!s5_it_d.done) begin
      s5_it_d.res    = d1_quo;
      s5_it_d.res_ok = 1'b1;
      s5_it_d.sat    = (d1_quo[31:8] >= clean_air_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_it_q  <= s5_it_d;
      s5_rem_q <= d1_quo[31:8];
      s5_lo_q  <= {d1_quo[7:0], 16'h0000};
    end
  end

  logic             d2_vld;
  logic [23:0]      d2_quo;
  logic [ItemW-1:0] d2_side;

  gspc_div #(.QW(24), .DW(24)) u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_vld_q),
    .rem_i   (s5_rem_q),
    .num_i   (s5_lo_q),
    .den_i   (clean_air_q),
    .side_i  (s5_it_q),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .side_o  (d2_side)
  );

  // ---------------- stage 6: ratio, normalize ----------------
  item_t       s6_it_d;
  logic [23:0] ratio;
  logic [4:0]  lead;
  logic [31:0] norm;

  always_comb begin
    s6_it_d = item_t'(d2_side);
    ratio   = s6_it_d.sat ? 24'hFF_FFFF : d2_quo;
    if (!s6_it_d.done && ratio == '0) begin
      s6_it_d.done = 1'b1;
    end
    lead = '0;
    for (int i = 0; i < 24; i++) begin
      if (ratio[i]) begin
        lead = 5'(i);
      end
    end
    norm = 32'(ratio) << (5'd31 - lead);
  end

  // log2 fraction by repeated squaring, one bit per stage
  logic        lg_vld  [17];
  item_t       lg_it   [17];
  logic [4:0]  lg_lead [17];
  logic [31:0] lg_m    [17];
  logic [15:0] lg_f    [17];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_vld[0] <= 1'b0;
    end else if (en) begin
      lg_vld[0] <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lg_it[0]   <= s6_it_d;
      lg_lead[0] <= lead;
      lg_m[0]    <= norm;
      lg_f[0]    <= '0;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_log
    logic [63:0] sq;
    logic [32:0] t;
    logic [31:0] m_d;
    logic [15:0] f_d;

    always_comb begin
      sq  = 64'(lg_m[k]) * 64'(lg_m[k]);
      t   = sq[63:31];
      f_d = lg_f[k];
      if (t[32]) begin
        m_d          = t[32:1];
        f_d[15 - k]  = 1'b1;
      end else begin
        m_d = t[31:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lg_vld[k+1] <= 1'b0;
      end else if (en) begin
        lg_vld[k+1] <= lg_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        lg_it[k+1]   <= lg_it[k];
        lg_lead[k+1] <= lg_lead[k];
        lg_m[k+1]    <= m_d;
        lg_f[k+1]    <= f_d;
      end
    end
  end

  // ---------------- exponent multiply ----------------
  logic signed [20:0] log_val;
  logic signed [41:0] prod;

  always_comb begin
    log_val = {5'(lg_lead[16] - 5'd16), lg_f[16]};
    prod    = 42'(exponent_q) * 42'(log_val);
  end

  // y = floor(prod / 2^16); integer and fraction parts of y
  logic               ex_vld [17];
  item_t              ex_it  [17];
  logic signed [9:0]  ex_yi  [17];
  logic [15:0]        ex_yf  [17];
  logic [31:0]        ex_r   [17];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld[0] <= 1'b0;
    end else if (en) begin
      ex_vld[0] <= lg_vld[16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_it[0] <= lg_it[16];
      ex_yi[0] <= prod[41:32];
      ex_yf[0] <= prod[31:16];
      ex_r[0]  <= 32'h4000_0000;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_exp
    localparam logic [31:0] CK = exp_const(k + 1);
    logic [63:0] pr;
    logic [31:0] r_d;

    always_comb begin
      pr  = 64'(ex_r[k]) * 64'(CK);
      r_d = ex_yf[k][15 - k] ? pr[61:30] : ex_r[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ex_vld[k+1] <= 1'b0;
      end else if (en) begin
        ex_vld[k+1] <= ex_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ex_it[k+1] <= ex_it[k];
        ex_yi[k+1] <= ex_yi[k];
        ex_yf[k+1] <= ex_yf[k];
        ex_r[k+1]  <= r_d;
      end
    end
  end

  // ---------------- scale by a ----------------
  logic              sa_vld_q;
  item_t             sa_it_q;
  logic signed [9:0] sa_yi_q;
  logic [63:0]       sa_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else if (en) begin
      sa_vld_q <= ex_vld[16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_it_q <= ex_it[16];
      sa_yi_q <= ex_yi[16];
      sa_p_q  <= 64'(scale_q) * 64'(ex_r[16]);
    end
  end

  // ---------------- shift to Q.8 ----------------
  logic               ss_vld_q;
  item_t              ss_it_q;
  logic               ss_ovf_q;
  logic [63:0]        ss_ppm_q;
  logic signed [10:0] sh;
  logic               ovf_d;
  logic [63:0]        ppm_d;

  always_comb begin
    sh    = 11'sd38 - 11'(sa_yi_q);
    ovf_d = (sh <= 11'sd0);
    if (ovf_d || sh >= 11'sd64) begin
      ppm_d = '0;
    end else begin
      ppm_d = sa_p_q >> sh[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_vld_q <= 1'b0;
    end else if (en) begin
      ss_vld_q <= sa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ss_it_q  <= sa_it_q;
      ss_ovf_q <= ovf_d;
      ss_ppm_q <= ppm_d;
    end
  end

  // ---------------- output register ----------------
  logic [1:0]         status_d, status_q;
  logic [21:0]        ppm_out_d, ppm_out_q;
  logic               ppm_ok_d, ppm_ok_q;
  logic signed [16:0] echo_q;
  logic [31:0]        res_q;
  logic               res_ok_q;

  always_comb begin
    status_d  = ss_it_q.status;
    ppm_out_d = '0;
    ppm_ok_d  = 1'b0;
    if (!ss_it_q.done) begin
      if (ss_ovf_q || ss_ppm_q > 64'(PPM_LIMIT)) begin
        status_d = ST_RANGE;
      end else begin
        status_d  = ST_OK;
        ppm_out_d = ss_ppm_q[21:0];
        ppm_ok_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ss_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q  <= status_d;
      ppm_out_q <= ppm_out_d;
      ppm_ok_q  <= ppm_ok_d;
      echo_q    <= ss_it_q.adc;
      res_q     <= ss_it_q.res;
      res_ok_q  <= ss_it_q.res_ok;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign adc_echo_mv_o    = echo_q;
  assign resistance_ohm_o = res_q;
  assign resistance_ok_o  = res_ok_q;
  assign co_ppm_o         = ppm_out_q;
  assign co_ppm_ok_o      = ppm_ok_q;

endmodule

// ===== sv/gspc_checker.sv =====
// Port-level checks for gas_sensor_ppm_convert, attached by bind.
// Depends on gspc_pkg for status codes and the ppm limit.
module gspc_checker import gspc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [1:0]          status_o,
  input logic [31:0]         resistance_ohm_o,
  input logic                resistance_ok_o,
  input logic [21:0]         co_ppm_o,
  input logic                co_ppm_ok_o
);

  a_ok_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |->
      co_ppm_ok_o && resistance_ok_o && co_ppm_o <= PPM_LIMIT)
    else $error("valid word without full result");

  a_cal_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_CAL |->
      resistance_ohm_o == '0 && !resistance_ok_o && !co_ppm_ok_o && co_ppm_o == '0)
    else $error("calibration-missing word carries data");

  a_ppm_needs_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (co_ppm_ok_o || status_o != ST_OK) |->
      (co_ppm_ok_o == (status_o == ST_OK)) && (!co_ppm_ok_o || resistance_ok_o))
    else $error("ppm flag inconsistent with status or resistance");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(co_ppm_o) && $stable(status_o))
    else $error("stalled output word changed");

endmodule

bind gas_sensor_ppm_convert gspc_checker u_gspc_checker (.*);
